// ===== src/pmmfn_pkg.sv =====
`timescale 1ns / 1ps

package pmmfn_pkg;

  // Width of the sample field on the input stream
  localparam int unsigned SAMPLE_FIELD_W = 16;

  // Fraction bits of the folded result (unsigned Q0.16)
  localparam int unsigned FRAC_W = 16;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

// ===== src/pmmfn_ram.sv =====
`timescale 1ns / 1ps

module pmmfn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/pmmfn_div.sv =====
`timescale 1ns / 1ps

// Restoring divider for a fraction num/den with num <= den.
// Gives floor(num * 2^FRAC_W / den), saturated to all ones when num == den.
module pmmfn_div #(
  parameter int unsigned W = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pmmfn_pkg::div_ctrl_t         ctrl_i,
  output pmmfn_pkg::div_ctrl_t         ctrl_o,
  input  logic [W-1:0]                 num_i,
  input  logic [W-1:0]                 den_i,
  output logic [pmmfn_pkg::FRAC_W-1:0] quot_o
);

  localparam int unsigned FW = pmmfn_pkg::FRAC_W;
  localparam int unsigned CNT_W = $clog2(FW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     den_q;
  logic [FW-1:0]    quot_q;

  logic [W:0]       shifted;
  logic             fits;
  logic [W:0]       diff;

  // One quotient bit per cycle
  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= ctrl_i.start ? (num_i >= den_i) : (busy_q && (cnt_q == CNT_W'(1)));
      if (ctrl_i.start) begin
        if (num_i < den_i) begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(FW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= (num_i >= den_i) ? '1 : '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[W-1:0] : shifted[W-1:0];
      quot_q <= {quot_q[FW-2:0], fits};
    end
  end

  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = done_q;
  assign quot_o       = quot_q;

endmodule

// ===== src/plane_minmax_fold_normalizer_top.sv =====
`timescale 1ns / 1ps

// Plane min-max fold normalizer. Signed samples of one plane stream in on the
// slave side, one beat per cycle, while the block stores them and tracks the
// plane minimum and maximum; tlast (or the PLANE_SIZE-th sample) closes the
// plane. The block then drops tready and sends one result per stored sample,
// in arrival order: |2(x-min) - (max-min)| / (max-min) as unsigned Q0.16,
// saturated at 65535, with tuser flagging a flat plane (max == min, value 0)
// and tlast on the result of the plane's final sample. After the close the range
// is formed (S_RANGE); then each result goes through a buffer read (S_READ),
// the numerator step (S_PREP), 16 steps of the restoring divider plus its handoff
// (S_DIV) and the load of the output register (S_HOLD), which waits while the
// output is stalled; a flat plane skips the divider. tready rises again once the
// last result of the plane sits in the output register.
module plane_minmax_fold_normalizer_top #(
  parameter int unsigned PLANE_SIZE   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  input  logic        s_axis_tlast,  // last_of_plane
  // Master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] folded_value
  output logic        m_axis_tuser,  // [0] degenerate
  output logic        m_axis_tlast   // last_result
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned FW   = pmmfn_pkg::FRAC_W;
  localparam int unsigned INW  = pmmfn_pkg::SAMPLE_FIELD_W;
  localparam int unsigned AW   = $clog2(PLANE_SIZE);
  localparam int unsigned CW   = $clog2(PLANE_SIZE + 1);

  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_RANGE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        idx_q;
  logic signed [SW-1:0] min_q, max_q;
  logic [SW-1:0]        range_q;
  logic                 degen_q;

  logic                 out_valid_q;
  logic [FW-1:0]        out_val_q;
  logic                 out_degen_q;
  logic                 out_last_q;

  logic [SW-1:0]        raw;
  logic signed [SW-1:0] x;
  logic                 s_acc;
  logic                 close;
  logic                 first;
  logic                 out_free;
  logic                 last_idx;

  logic [SW-1:0]        rd_data;
  logic [SW-1:0]        delta;
  logic [SW:0]          twice;
  logic [SW:0]          rng_ext;
  logic [SW:0]          num_full;

  pmmfn_pkg::div_ctrl_t div_req, div_stat;
  logic [FW-1:0]        div_quot;

  // Sample extraction: low SAMPLE_WIDTH bits (zero-extended above the 16-bit field), sign from bit SAMPLE_WIDTH-1
  if (SW <= INW) begin : g_narrow
    assign raw = s_axis_tdata[SW-1:0];
  end else begin : g_wide
    assign raw = {{(SW - INW){1'b0}}, s_axis_tdata};
  end
  assign x = $signed(raw);

  assign s_axis_tready = (state_q == S_FILL);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign first         = (cnt_q == '0);
  assign close         = s_axis_tlast || ((cnt_q + CW'(1)) == CW'(PLANE_SIZE));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign last_idx      = ((idx_q + CW'(1)) == cnt_q);

  // Plane buffer
  pmmfn_ram #(
    .WIDTH (SW),
    .DEPTH (PLANE_SIZE)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (s_acc),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (raw),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Numerator |2(x-min) - range|, never above range
  assign delta    = rd_data - min_q;
  assign twice    = {delta, 1'b0};
  assign rng_ext  = {1'b0, range_q};
  assign num_full = (twice >= rng_ext) ? (twice - rng_ext) : (rng_ext - twice);

  assign div_req.start = (state_q == S_PREP) && !degen_q;
  assign div_req.done  = 1'b0;

  pmmfn_div #(
    .W (SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_req),
    .ctrl_o (div_stat),
    .num_i  (num_full[SW-1:0]),
    .den_i  (range_q),
    .quot_o (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_FILL:  if (s_acc && close) state_d = S_RANGE;
      S_RANGE: state_d = S_READ;
      S_READ:  state_d = S_PREP;
      S_PREP:  state_d = degen_q ? S_HOLD : S_DIV;
      S_DIV:   if (div_stat.done) state_d = S_HOLD;
      S_HOLD: begin
        if (out_free) state_d = last_idx ? S_FILL : S_READ;
      end
      default: state_d = S_FILL;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_acc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == S_RANGE) begin
        idx_q <= '0;
      end
      if (state_q == S_HOLD && out_free) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + CW'(1);
        if (last_idx) begin
          cnt_q <= '0;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Plane statistics and output payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      if (first || x < min_q) min_q <= x;
      if (first || x > max_q) max_q <= x;
    end
    if (state_q == S_RANGE) begin
      range_q <= max_q - min_q;
      degen_q <= (max_q == min_q);
    end
    if (state_q == S_HOLD && out_free) begin
      out_val_q   <= degen_q ? '0 : div_quot;
      out_degen_q <= degen_q;
      out_last_q  <= last_idx;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_degen_q;
  assign m_axis_tlast  = out_last_q;

endmodule
